[rtl/core/tlgs_pkg.sv]
// Shared definitions for the toroidal Life grid stepper: field widths,
// action codes and configuration register indexes.
// No dependencies; imported by toroidal_life_grid_stepper_core.
package tlgs_pkg;

   // Field widths of the request, response and configuration beats
   localparam int ACTION_W    = 2;
   localparam int COORD_W     = 6;
   localparam int COUNT_W     = 4;
   localparam int SIZE_W      = 7;
   localparam int FIRST_W     = 6;
   localparam int RULE_W      = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 7;

   // Smallest grid side in use
   localparam int MIN_SIDE = 3;

   // Request actions
   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_STEP  = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_FIRST  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_END    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SURVIVE_MIN = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SURVIVE_MAX = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIRTH_MIN   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIRTH_MAX   = 3'd7;

   // Register values after reset
   localparam logic [SIZE_W-1:0]  RST_GRID_WIDTH  = 7'd64;
   localparam logic [SIZE_W-1:0]  RST_GRID_HEIGHT = 7'd64;
   localparam logic [FIRST_W-1:0] RST_BAND_FIRST  = 6'd0;
   localparam logic [SIZE_W-1:0]  RST_BAND_END    = 7'd64;
   localparam logic [RULE_W-1:0]  RST_SURVIVE_MIN = 4'd2;
   localparam logic [RULE_W-1:0]  RST_SURVIVE_MAX = 4'd3;
   localparam logic [RULE_W-1:0]  RST_BIRTH_MIN   = 4'd3;
   localparam logic [RULE_W-1:0]  RST_BIRTH_MAX   = 4'd3;

endpackage

[rtl/core/tlgs_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies; used for the cell grid and the neighbour count store.
module tlgs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/toroidal_life_grid_stepper_core.sv]
// Toroidal Life grid stepper: cell store, neighbour count store and the step sequencer.
// Depends on tlgs_pkg (widths, action and register codes) and tlgs_ram (row-wide stores).
//
//  Channel   Direction  Handshake            Beat contents
//  req_*     in         req_valid/req_stall  action, column, row, alive_in
//  rsp_*     out        rsp_valid/rsp_stall  cell_alive, neighbor_count, status
//  csr_*     in         csr_valid/csr_ready  register index, write data
//
// A cell write or read goes from decode through a cell access to the result state; a
// coordinate outside the grid, an empty band or the unused action skip the cell access.
// A step sweeps the band row by row over the columns in use:
// one shared neighbour counter visits one cell per cycle, and each row adds states
// for loading the next grid row, loading the old count row and writing both back.
// Reset is synchronous and active high. It is followed by a clearing pass that writes
// every grid row and count row to zero; no request is taken meanwhile, while
// configuration writes are taken as ever.
// req_stall is high whenever the sequencer is busy. A finished result waits in the response
// register under rsp_stall while the next request is already taken and worked on.
module toroidal_life_grid_stepper_core
   import tlgs_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [ACTION_W-1:0]    req_action,
   input  logic [COORD_W-1:0]     req_column,
   input  logic [COORD_W-1:0]     req_row,
   input  logic                   req_alive_in,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_cell_alive,
   output logic [COUNT_W-1:0]     rsp_neighbor_count,
   output logic                   rsp_status,
   // configuration write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Column index, row index and the widths that can hold a side length itself
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WN = $clog2(MAX_WIDTH + 1);
   localparam int HN = $clog2(MAX_HEIGHT + 1);

   // Sequencer states
   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_DECODE  = 4'd2;
   localparam logic [3:0] S_CELL    = 4'd3;
   localparam logic [3:0] S_LD_PREV = 4'd4;
   localparam logic [3:0] S_LD_CUR  = 4'd5;
   localparam logic [3:0] S_LD_NEXT = 4'd6;
   localparam logic [3:0] S_CNT_LD  = 4'd7;
   localparam logic [3:0] S_SWEEP   = 4'd8;
   localparam logic [3:0] S_WB      = 4'd9;
   localparam logic [3:0] S_RESULT  = 4'd10;

   // One row of stored neighbour counts, one nibble per column
   typedef logic [MAX_WIDTH-1:0][COUNT_W-1:0] cnt_row_type;

   // Control state
   logic [3:0]           state_ff, state_in;
   logic [RW-1:0]        clr_row_ff, clr_row_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Configuration registers
   logic [SIZE_W-1:0]    grid_width_ff, grid_width_in;
   logic [SIZE_W-1:0]    grid_height_ff, grid_height_in;
   logic [FIRST_W-1:0]   band_first_ff, band_first_in;
   logic [SIZE_W-1:0]    band_end_ff, band_end_in;
   logic [RULE_W-1:0]    survive_min_ff, survive_min_in;
   logic [RULE_W-1:0]    survive_max_ff, survive_max_in;
   logic [RULE_W-1:0]    birth_min_ff, birth_min_in;
   logic [RULE_W-1:0]    birth_max_ff, birth_max_in;

   // Request held for the duration of one item
   logic [ACTION_W-1:0]  act_ff, act_in;
   logic [COORD_W-1:0]   col_ff, col_in;
   logic [COORD_W-1:0]   row_ff, row_in;
   logic                 alive_ff, alive_in;

   // Step working set: three old grid rows around the current one, an old copy of the
   // band's first row for the wrap at the bottom, the row being built and its counts
   logic [RW-1:0]        y_ff, y_in;
   logic [CW-1:0]        x_ff, x_in;
   logic [MAX_WIDTH-1:0] win_prev_ff, win_prev_in;
   logic [MAX_WIDTH-1:0] win_cur_ff, win_cur_in;
   logic [MAX_WIDTH-1:0] win_next_ff, win_next_in;
   logic [MAX_WIDTH-1:0] first_old_ff, first_old_in;
   logic [MAX_WIDTH-1:0] new_row_ff, new_row_in;
   cnt_row_type          cnt_row_ff, cnt_row_in;

   // Result waiting for the response register, and the response register itself
   logic                 res_alive_ff, res_alive_in;
   logic [COUNT_W-1:0]   res_count_ff, res_count_in;
   logic                 res_status_ff, res_status_in;
   logic                 rsp_alive_ff, rsp_alive_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_status_ff, rsp_status_in;
   logic                 rsp_load;

   // Store ports
   logic                 grid_we;
   logic [RW-1:0]        grid_waddr, grid_raddr;
   logic [MAX_WIDTH-1:0] grid_wdata, grid_rd_data;
   logic                 cnt_we;
   logic [RW-1:0]        cnt_waddr, cnt_raddr;
   cnt_row_type          cnt_wdata;
   logic [MAX_WIDTH*COUNT_W-1:0] cnt_rd_data;
   cnt_row_type          cnt_rd_row;

   // Derived geometry
   logic [WN-1:0]        w_use;
   logic [HN-1:0]        h_use;
   logic [HN-1:0]        end_use;
   logic                 band_empty;
   logic                 out_of_range;
   logic [CW-1:0]        col_idx;
   logic [RW-1:0]        row_idx;
   logic [RW-1:0]        first_idx;
   logic [RW:0]          y_inc;
   logic [CW:0]          x_inc;
   logic [MAX_WIDTH-1:0] cell_row_mod;

   // Shared neighbour counter
   logic [CW-1:0]        x_left, x_right;
   logic [COUNT_W-1:0]   nb_count;
   logic                 cell_next;

   function automatic logic [RW-1:0] row_next(input logic [RW-1:0] r,
                                              input logic [HN-1:0] h);
      logic [RW:0] r_inc;
      r_inc = {1'b0, r} + 1'b1;
      return (r_inc == h) ? '0 : r_inc[RW-1:0];
   endfunction

   function automatic logic [RW-1:0] row_prev(input logic [RW-1:0] r,
                                              input logic [HN-1:0] h);
      logic [HN-1:0] h_dec;
      h_dec = h - 1'b1;
      return (r == '0) ? RW'(h_dec) : r - 1'b1;
   endfunction

   tlgs_ram #(
      .WIDTH (MAX_WIDTH),
      .DEPTH (MAX_HEIGHT)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (grid_we),
      .wr_addr (grid_waddr),
      .wr_data (grid_wdata),
      .rd_addr (grid_raddr),
      .rd_data (grid_rd_data)
   );

   tlgs_ram #(
      .WIDTH (MAX_WIDTH * COUNT_W),
      .DEPTH (MAX_HEIGHT)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rd_data)
   );

   assign cnt_rd_row = cnt_rd_data;

   // The sizes in use are the registers saturated to [3, MAX]. The band end is saturated
   // to the height in use, and a band whose end is not above its first row is empty.
   always_comb begin
      if (grid_width_ff < SIZE_W'(MIN_SIDE)) begin
         w_use = WN'(MIN_SIDE);
      end else if (32'(grid_width_ff) > MAX_WIDTH) begin
         w_use = WN'(MAX_WIDTH);
      end else begin
         w_use = WN'(grid_width_ff);
      end
      if (grid_height_ff < SIZE_W'(MIN_SIDE)) begin
         h_use = HN'(MIN_SIDE);
      end else if (32'(grid_height_ff) > MAX_HEIGHT) begin
         h_use = HN'(MAX_HEIGHT);
      end else begin
         h_use = HN'(grid_height_ff);
      end
      if (32'(band_end_ff) > 32'(h_use)) begin
         end_use = h_use;
      end else begin
         end_use = HN'(band_end_ff);
      end
   end

   assign band_empty   = (32'(end_use) <= 32'(band_first_ff));
   assign out_of_range = (32'(col_ff) >= 32'(w_use)) || (32'(row_ff) >= 32'(h_use));
   // Only used once the coordinate is known to lie inside the grid, or the band non-empty
   assign col_idx      = CW'(col_ff);
   assign row_idx      = RW'(row_ff);
   assign first_idx    = RW'(band_first_ff);
   assign y_inc        = {1'b0, y_ff} + 1'b1;
   assign x_inc        = {1'b0, x_ff} + 1'b1;

   always_comb begin
      cell_row_mod          = grid_rd_data;
      cell_row_mod[col_idx] = alive_ff;
   end

   // Neighbour count of cell x of the current row from the three old rows, with the
   // columns wrapping at the width in use, followed by the survive or birth rule.
   always_comb begin
      x_left    = (x_ff == '0) ? CW'(w_use - 1'b1) : x_ff - 1'b1;
      x_right   = (x_inc == 32'(w_use)) ? '0 : x_inc[CW-1:0];
      nb_count  = {3'b000, win_prev_ff[x_left]} + {3'b000, win_prev_ff[x_ff]}
                + {3'b000, win_prev_ff[x_right]} + {3'b000, win_cur_ff[x_left]}
                + {3'b000, win_cur_ff[x_right]} + {3'b000, win_next_ff[x_left]}
                + {3'b000, win_next_ff[x_ff]} + {3'b000, win_next_ff[x_right]};
      if (win_cur_ff[x_ff]) begin
         cell_next = (nb_count >= survive_min_ff) && (nb_count <= survive_max_ff);
      end else begin
         cell_next = (nb_count >= birth_min_ff) && (nb_count <= birth_max_ff);
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_row_in    = clr_row_ff;
      act_in        = act_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      alive_in      = alive_ff;
      y_in          = y_ff;
      x_in          = x_ff;
      win_prev_in   = win_prev_ff;
      win_cur_in    = win_cur_ff;
      win_next_in   = win_next_ff;
      first_old_in  = first_old_ff;
      new_row_in    = new_row_ff;
      cnt_row_in    = cnt_row_ff;
      res_alive_in  = res_alive_ff;
      res_count_in  = res_count_ff;
      res_status_in = res_status_ff;
      rsp_load      = 1'b0;
      grid_we       = 1'b0;
      grid_waddr    = y_ff;
      grid_wdata    = new_row_ff;
      grid_raddr    = y_ff;
      cnt_we        = 1'b0;
      cnt_waddr     = y_ff;
      cnt_wdata     = cnt_row_ff;
      cnt_raddr     = y_ff;

      case (state_ff)
         S_CLEAR: begin
            grid_we    = 1'b1;
            grid_waddr = clr_row_ff;
            grid_wdata = '0;
            cnt_we     = 1'b1;
            cnt_waddr  = clr_row_ff;
            cnt_wdata  = '0;
            clr_row_in = clr_row_ff + 1'b1;
            if (clr_row_ff == RW'(MAX_HEIGHT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               act_in   = req_action;
               col_in   = req_column;
               row_in   = req_row;
               alive_in = req_alive_in;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_alive_in  = 1'b0;
            res_count_in  = '0;
            res_status_in = 1'b0;
            state_in      = S_RESULT;
            case (act_ff)
               ACT_WRITE, ACT_READ: begin
                  if (out_of_range) begin
                     res_status_in = 1'b1;
                  end else begin
                     grid_raddr = row_idx;
                     cnt_raddr  = row_idx;
                     state_in   = S_CELL;
                  end
               end
               ACT_STEP: begin
                  if (!band_empty) begin
                     y_in       = first_idx;
                     grid_raddr = row_prev(first_idx, h_use);
                     state_in   = S_LD_PREV;
                  end
               end
               default: begin
               end
            endcase
         end
         S_CELL: begin
            res_count_in  = cnt_rd_row[col_idx];
            res_status_in = 1'b0;
            if (act_ff == ACT_WRITE) begin
               res_alive_in = alive_ff;
               grid_we      = 1'b1;
               grid_waddr   = row_idx;
               grid_wdata   = cell_row_mod;
            end else begin
               res_alive_in = grid_rd_data[col_idx];
            end
            state_in = S_RESULT;
         end
         S_LD_PREV: begin
            win_prev_in = grid_rd_data;
            grid_raddr  = y_ff;
            state_in    = S_LD_CUR;
         end
         S_LD_CUR: begin
            win_cur_in   = grid_rd_data;
            first_old_in = grid_rd_data;
            grid_raddr   = row_next(y_ff, h_use);
            state_in     = S_LD_NEXT;
         end
         S_LD_NEXT: begin
            // The first band row is already updated when the band wraps round to it
            if (row_next(y_ff, h_use) == first_idx) begin
               win_next_in = first_old_ff;
            end else begin
               win_next_in = grid_rd_data;
            end
            cnt_raddr = y_ff;
            state_in  = S_CNT_LD;
         end
         S_CNT_LD: begin
            cnt_row_in = cnt_rd_row;
            new_row_in = win_cur_ff;
            x_in       = '0;
            state_in   = S_SWEEP;
         end
         S_SWEEP: begin
            cnt_row_in[x_ff] = nb_count;
            new_row_in[x_ff] = cell_next;
            x_in             = x_inc[CW-1:0];
            if (x_inc == 32'(w_use)) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            grid_we = 1'b1;
            cnt_we  = 1'b1;
            if (y_inc == 32'(end_use)) begin
               res_alive_in  = 1'b0;
               res_count_in  = '0;
               res_status_in = 1'b0;
               state_in      = S_RESULT;
            end else begin
               y_in        = y_inc[RW-1:0];
               win_prev_in = win_cur_ff;
               win_cur_in  = win_next_ff;
               grid_raddr  = row_next(row_next(y_ff, h_use), h_use);
               state_in    = S_LD_NEXT;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response register
   always_comb begin
      rsp_valid_in  = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_alive_in  = rsp_load ? res_alive_ff  : rsp_alive_ff;
      rsp_count_in  = rsp_load ? res_count_ff  : rsp_count_ff;
      rsp_status_in = rsp_load ? res_status_ff : rsp_status_ff;
   end

   // Configuration writes; every write is taken at once
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      band_first_in  = band_first_ff;
      band_end_in    = band_end_ff;
      survive_min_in = survive_min_ff;
      survive_max_in = survive_max_ff;
      birth_min_in   = birth_min_ff;
      birth_max_in   = birth_max_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GRID_WIDTH:  grid_width_in  = csr_wdata[SIZE_W-1:0];
            CSR_GRID_HEIGHT: grid_height_in = csr_wdata[SIZE_W-1:0];
            CSR_BAND_FIRST:  band_first_in  = csr_wdata[FIRST_W-1:0];
            CSR_BAND_END:    band_end_in    = csr_wdata[SIZE_W-1:0];
            CSR_SURVIVE_MIN: survive_min_in = csr_wdata[RULE_W-1:0];
            CSR_SURVIVE_MAX: survive_max_in = csr_wdata[RULE_W-1:0];
            CSR_BIRTH_MIN:   birth_min_in   = csr_wdata[RULE_W-1:0];
            CSR_BIRTH_MAX:   birth_max_in   = csr_wdata[RULE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_row_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         grid_width_ff  <= RST_GRID_WIDTH;
         grid_height_ff <= RST_GRID_HEIGHT;
         band_first_ff  <= RST_BAND_FIRST;
         band_end_ff    <= RST_BAND_END;
         survive_min_ff <= RST_SURVIVE_MIN;
         survive_max_ff <= RST_SURVIVE_MAX;
         birth_min_ff   <= RST_BIRTH_MIN;
         birth_max_ff   <= RST_BIRTH_MAX;
      end else begin
         state_ff       <= state_in;
         clr_row_ff     <= clr_row_in;
         rsp_valid_ff   <= rsp_valid_in;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         band_first_ff  <= band_first_in;
         band_end_ff    <= band_end_in;
         survive_min_ff <= survive_min_in;
         survive_max_ff <= survive_max_in;
         birth_min_ff   <= birth_min_in;
         birth_max_ff   <= birth_max_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      alive_ff      <= alive_in;
      y_ff          <= y_in;
      x_ff          <= x_in;
      win_prev_ff   <= win_prev_in;
      win_cur_ff    <= win_cur_in;
      win_next_ff   <= win_next_in;
      first_old_ff  <= first_old_in;
      new_row_ff    <= new_row_in;
      cnt_row_ff    <= cnt_row_in;
      res_alive_ff  <= res_alive_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
      rsp_alive_ff  <= rsp_alive_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_alive     = rsp_alive_ff;
   assign rsp_neighbor_count = rsp_count_ff;
   assign rsp_status         = rsp_status_ff;
   assign csr_ready          = 1'b1;

endmodule

[tb/toroidal_life_grid_stepper_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for toroidal_life_grid_stepper_core: directed and random cell
// writes, reads and generation steps over many grid sizes, bands and rules.
// Depends on tlgs_pkg and the core RTL only.
module toroidal_life_grid_stepper_core_tb;
   import tlgs_pkg::*;

   // The grid side the core is built with; it is also the row stride of both stores.
   localparam int MAX_SIDE    = 64;
   localparam int CELL_TOTAL  = MAX_SIDE * MAX_SIDE;
   // The fourth action code has no function and must leave the grid alone.
   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
   // Far above the slowest correct run.
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_ITEMS = 1200;

   // One response beat as the shadow grid expects it.
   typedef struct packed {
      logic               alive;
      logic [COUNT_W-1:0] count;
      logic               status;
   } cell_result_type;

   // Shadow copy of the grid, the stored neighbour counts and the register file. Every
   // accepted request beat is played on it at once, and the response it should cause is
   // queued until the matching response beat comes out of the core.
   class life_grid_shadow;
      bit                 alive_map [CELL_TOTAL];
      bit [COUNT_W-1:0]   count_map [CELL_TOTAL];
      bit [SIZE_W-1:0]    width_reg    = RST_GRID_WIDTH;
      bit [SIZE_W-1:0]    height_reg   = RST_GRID_HEIGHT;
      bit [FIRST_W-1:0]   first_reg    = RST_BAND_FIRST;
      bit [SIZE_W-1:0]    end_reg      = RST_BAND_END;
      bit [RULE_W-1:0]    survive_lo   = RST_SURVIVE_MIN;
      bit [RULE_W-1:0]    survive_hi   = RST_SURVIVE_MAX;
      bit [RULE_W-1:0]    birth_lo     = RST_BIRTH_MIN;
      bit [RULE_W-1:0]    birth_hi     = RST_BIRTH_MAX;
      cell_result_type    awaited [$];
      int                 mismatches = 0;

      // Sizes below three or above the built size are saturated by the core.
      function int clamp_side(bit [SIZE_W-1:0] side);
         if (side < MIN_SIDE) return MIN_SIDE;
         if (side > MAX_SIDE) return MAX_SIDE;
         return int'(side);
      endfunction

      function void apply_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_GRID_WIDTH:  width_reg  = data;
            CSR_GRID_HEIGHT: height_reg = data;
            CSR_BAND_FIRST:  first_reg  = data[FIRST_W-1:0];
            CSR_BAND_END:    end_reg    = data;
            CSR_SURVIVE_MIN: survive_lo = data[RULE_W-1:0];
            CSR_SURVIVE_MAX: survive_hi = data[RULE_W-1:0];
            CSR_BIRTH_MIN:   birth_lo   = data[RULE_W-1:0];
            CSR_BIRTH_MAX:   birth_hi   = data[RULE_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_request(logic [ACTION_W-1:0] action, logic [COORD_W-1:0] col,
                                 logic [COORD_W-1:0] row, logic alive_in);
         cell_result_type want;
         int w, h, addr, band_end, live, ny, nx, n;
         want = '0;
         w = clamp_side(width_reg);
         h = clamp_side(height_reg);
         case (action)
            ACT_WRITE, ACT_READ: begin
               if (col >= w || row >= h) begin
                  want.status = 1'b1;
               end else begin
                  addr = row * MAX_SIDE + col;
                  if (action == ACT_WRITE) alive_map[addr] = alive_in;
                  want.alive = alive_map[addr];
                  want.count = count_map[addr];
               end
            end
            ACT_STEP: begin
               // Counts come from the old grid for the whole band before any cell changes.
               band_end = (end_reg > h) ? h : end_reg;
               for (int y = first_reg; y < band_end; y++) begin
                  for (int x = 0; x < w; x++) begin
                     live = 0;
                     for (int dy = 0; dy < 3; dy++) begin
                        ny = (y + h - 1 + dy) % h;
                        for (int dx = 0; dx < 3; dx++) begin
                           nx = (x + w - 1 + dx) % w;
                           if (dx != 1 || dy != 1) live += int'(alive_map[ny * MAX_SIDE + nx]);
                        end
                     end
                     count_map[y * MAX_SIDE + x] = COUNT_W'(live);
                  end
               end
               for (int y = first_reg; y < band_end; y++) begin
                  for (int x = 0; x < w; x++) begin
                     addr = y * MAX_SIDE + x;
                     n = int'(count_map[addr]);
                     if (alive_map[addr]) alive_map[addr] = (n >= survive_lo && n <= survive_hi);
                     else                 alive_map[addr] = (n >= birth_lo && n <= birth_hi);
                  end
               end
            end
            default: ;
         endcase
         awaited.push_back(want);
      endfunction

      function void compare_result(logic alive, logic [COUNT_W-1:0] count, logic status);
         cell_result_type want;
         if (awaited.size() == 0) begin
            $display("%0t: response beat with nothing outstanding: alive %0b count %0d status %0b",
                     $time, alive, count, status);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         if (alive !== want.alive) begin
            $display("%0t: cell_alive expected %0b actual %0b", $time, want.alive, alive);
            mismatches++;
         end
         if (count !== want.count) begin
            $display("%0t: neighbor_count expected %0d actual %0d", $time, want.count, count);
            mismatches++;
         end
         if (status !== want.status) begin
            $display("%0t: status expected %0b actual %0b", $time, want.status, status);
            mismatches++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [ACTION_W-1:0]    req_action = '0;
   logic [COORD_W-1:0]     req_column = '0;
   logic [COORD_W-1:0]     req_row = '0;
   logic                   req_alive_in = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_cell_alive;
   logic [COUNT_W-1:0]     rsp_neighbor_count;
   logic                   rsp_status;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   life_grid_shadow shadow;
   int              beats_sent = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              cycle_count = 0;

   toroidal_life_grid_stepper_core #(
      .MAX_WIDTH  (MAX_SIDE),
      .MAX_HEIGHT (MAX_SIDE)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_column         (req_column),
      .req_row            (req_row),
      .req_alive_in       (req_alive_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cell_alive     (rsp_cell_alive),
      .rsp_neighbor_count (rsp_neighbor_count),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   // Everything sampled here is the value held just before the edge, so a beat is seen
   // exactly when the core takes it. Responses are checked before the request of the same
   // edge is played, though the core cannot answer a request on the edge that takes it.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            shadow.compare_result(rsp_cell_alive, rsp_neighbor_count, rsp_status);
         if (req_valid && !req_stall)
            shadow.take_request(req_action, req_column, req_row, req_alive_in);
      end
   end

   // The response side holds off at random; a new draw is made on every edge so that the
   // stall lands on every phase of a step sweep as well as on single cell accesses.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("toroidal_life_grid_stepper_core_tb: FAIL");
         $finish;
      end
   end

   // Presents one request beat and returns on the edge that takes it. Idle cycles go in
   // front of the beat, so valid is only ever raised or lowered once per edge. The idling
   // mix moves on with the number of beats sent: sender eager and receiver often stalled first,
   // then the reverse, then both sides flat out.
   task automatic put_request(input logic [ACTION_W-1:0] action, input int col, input int row,
                              input logic alive);
      if (beats_sent < RANDOM_ITEMS / 3) begin
         send_idle_pct = 22;
         recv_idle_pct = 49;
      end else if (beats_sent < 2 * RANDOM_ITEMS / 3) begin
         send_idle_pct = 49;
         recv_idle_pct = 22;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= action;
      req_column   <= col[COORD_W-1:0];
      req_row      <= row[COORD_W-1:0];
      req_alive_in <= alive;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   // Called on the edge that took the last request beat: drops valid there and waits until
   // every response has come back and the sequencer is free again.
   task automatic finish_batch();
      req_valid <= 1'b0;
      do @(posedge clock); while (shadow.awaited.size() != 0 || req_stall);
   endtask

   // Leaves valid high so that the next write can follow on the same edge.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      shadow.apply_csr(idx, value[CSR_DATA_W-1:0]);
   endtask

   task automatic load_settings(input int w, input int h, input int first, input int band_end,
                                input int s_lo, input int s_hi, input int b_lo, input int b_hi);
      finish_batch();
      write_csr(CSR_GRID_WIDTH, w);
      write_csr(CSR_GRID_HEIGHT, h);
      write_csr(CSR_BAND_FIRST, first);
      write_csr(CSR_BAND_END, band_end);
      write_csr(CSR_SURVIVE_MIN, s_lo);
      write_csr(CSR_SURVIVE_MAX, s_hi);
      write_csr(CSR_BIRTH_MIN, b_lo);
      write_csr(CSR_BIRTH_MAX, b_hi);
      csr_valid <= 1'b0;
   endtask

   // One random phase: a fresh grid size, band and rule, then a run of beats that mostly
   // loads patterns inside the grid, reads them back and steps them, with some coordinates
   // outside the grid, the spare action and fully random beats mixed in. Most grids are small
   // so that a step sweep stays short; now and then the grid is near or above the built size.
   task automatic run_random_batch();
      int  w_val, h_val, w_eff, h_eff, first_val, end_val, n, pick, step_pct, col, row;
      int  s_lo, s_hi, b_lo, b_hi;
      bit  big;
      big = ($urandom_range(7) == 0);
      if (big) begin
         w_val = $urandom_range(127, 60);
         h_val = $urandom_range(127, 60);
      end else begin
         w_val = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(12, 3);
         h_val = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(12, 3);
      end
      w_eff = shadow.clamp_side(SIZE_W'(w_val));
      h_eff = shadow.clamp_side(SIZE_W'(h_val));
      first_val = ($urandom_range(5) == 0) ? $urandom_range(63) : $urandom_range(h_eff - 1);
      case ($urandom_range(5))
         0:       end_val = $urandom_range(127);
         1:       end_val = 0;
         default: end_val = first_val + $urandom_range(h_eff, 1);
      endcase
      case ($urandom_range(3))
         0: begin s_lo = 2; s_hi = 3; b_lo = 3; b_hi = 3; end
         1: begin s_lo = 2; s_hi = 3; b_lo = 2; b_hi = 3; end
         2: begin
            s_lo = $urandom_range(8); s_hi = $urandom_range(8);
            b_lo = $urandom_range(8); b_hi = $urandom_range(8);
         end
         default: begin
            // Raw seven-bit data: the core keeps the low four bits, which may exceed eight.
            s_lo = $urandom_range(127); s_hi = $urandom_range(127);
            b_lo = $urandom_range(127); b_hi = $urandom_range(127);
         end
      endcase
      load_settings(w_val, h_val, first_val, end_val, s_lo, s_hi, b_lo, b_hi);
      step_pct = big ? 2 : 12;
      n = $urandom_range(70, 30);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < step_pct) begin
            put_request(ACT_STEP, $urandom_range(63), $urandom_range(63), 1'($urandom_range(1)));
         end else if (pick < 50) begin
            put_request(ACT_WRITE, $urandom_range(w_eff - 1), $urandom_range(h_eff - 1),
                        $urandom_range(99) < 55);
         end else if (pick < 78) begin
            put_request(ACT_READ, $urandom_range(w_eff - 1), $urandom_range(h_eff - 1),
                        1'($urandom_range(1)));
         end else if (pick < 88) begin
            // Outside the grid in use where it is smaller than the built size, on one axis or both.
            col = $urandom_range(63);
            row = $urandom_range(63);
            if (w_eff < MAX_SIDE && $urandom_range(1)) begin
               col = $urandom_range(63, w_eff);
               row = $urandom_range(h_eff - 1);
            end else if (h_eff < MAX_SIDE) begin
               row = $urandom_range(63, h_eff);
            end
            put_request($urandom_range(1) ? ACT_WRITE : ACT_READ, col, row,
                        1'($urandom_range(1)));
         end else if (pick < 93) begin
            put_request(ACT_SPARE, $urandom_range(63), $urandom_range(63),
                        1'($urandom_range(1)));
         end else begin
            put_request(ACTION_W'($urandom_range(3)), $urandom_range(63), $urandom_range(63),
                        1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      shadow = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Settings as after reset: full 64 by 64 torus, classic rule, band over every row.
      // The four corners are neighbours of one another across both wrap seams.
      put_request(ACT_WRITE, 0, 0, 1'b1);
      put_request(ACT_WRITE, 63, 0, 1'b1);
      put_request(ACT_WRITE, 0, 63, 1'b1);
      put_request(ACT_WRITE, 63, 63, 1'b1);
      put_request(ACT_READ, 63, 63, 1'b0);
      put_request(ACT_SPARE, 63, 63, 1'b1);
      put_request(ACT_STEP, 0, 0, 1'b0);
      put_request(ACT_READ, 0, 0, 1'b0);
      put_request(ACT_READ, 1, 1, 1'b1);
      put_request(ACT_WRITE, 0, 0, 1'b0);

      // A band of the last row only, its end saturated to the height, alternate rule.
      load_settings(64, 64, 63, 127, 2, 3, 2, 3);
      put_request(ACT_WRITE, 9, 62, 1'b1);
      put_request(ACT_WRITE, 10, 62, 1'b1);
      put_request(ACT_WRITE, 11, 62, 1'b1);
      put_request(ACT_STEP, 0, 0, 1'b0);
      put_request(ACT_READ, 10, 63, 1'b0);

      // Sizes below the minimum give a 3 by 3 grid. Every live cell survives and the birth
      // range is empty, so no cell is ever born.
      load_settings(0, 1, 0, 2, 0, 8, 8, 0);
      put_request(ACT_WRITE, 3, 0, 1'b1);
      put_request(ACT_READ, 0, 3, 1'b0);
      put_request(ACT_WRITE, 2, 2, 1'b1);
      put_request(ACT_WRITE, 0, 0, 1'b1);
      put_request(ACT_STEP, 0, 0, 1'b0);
      put_request(ACT_READ, 2, 2, 1'b0);
      put_request(ACT_READ, 1, 1, 1'b0);

      // Band end at zero: the band is empty and a step must change nothing.
      finish_batch();
      write_csr(CSR_BAND_END, 0);
      csr_valid <= 1'b0;
      put_request(ACT_STEP, 0, 0, 1'b0);
      put_request(ACT_READ, 0, 0, 1'b0);

      beats_sent = 0;
      while (beats_sent < RANDOM_ITEMS) run_random_batch();
      finish_batch();
      repeat (16) @(posedge clock);

      if (shadow.mismatches == 0 && shadow.awaited.size() == 0) begin
         $display("toroidal_life_grid_stepper_core_tb: PASS");
      end else begin
         $display("toroidal_life_grid_stepper_core_tb: FAIL");
      end
      $finish;
   end

endmodule

[toroidal_life_grid_stepper_core.f]
rtl/core/tlgs_pkg.sv
rtl/core/tlgs_ram.sv
rtl/core/toroidal_life_grid_stepper_core.sv
tb/toroidal_life_grid_stepper_core_tb.sv
